>>> rtl/aip_pkg.sv
package aip_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;
  localparam int RES_VAL_W   = 64;
  localparam int RES_CNT_W   = 16;
  localparam int BASE_W      = 5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_CASE  = 8'h20;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

  typedef enum logic [5:0] {
    PH_DONE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_PREFIX = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t char_digit(input logic [7:0] ch);
    digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d.val = 4'(ch - CH_ZERO);
    end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
      d.val = 4'(ch - CH_LC_A + 8'd10);
    end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
      d.val = 4'(ch - CH_UC_A + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

>>> rtl/ascii_integer_parser.sv
// ascii_integer_parser: converts a character stream into signed integers.
//
// Input channel (in_*): one character per transfer. in_tuser high marks the
// first character of a new string and samples the radix in in_tdata[12:8]
// (0 detects it from a 0, 0x or 0X prefix). Leading white space and one sign
// are taken, then digits below the radix build the value modulo
// 2^VALUE_WIDTH.
// Output channel (out_*): one transfer per string, produced by the first
// character that is not accepted: the signed value and the number of
// characters consumed before it (saturating). Characters after that are
// dropped until the next string start; a start mid-string drops the
// unfinished parse without a result.
// Timing: one character per cycle while in_tready is high. A result appears in
// the output register in the cycle after the ending character is taken; the
// accumulator path holds a single multiply-add by the radix between the state
// registers. A stalled output holds in_tready low only while the output
// register is full and out_tready is low.
// Reset: rst_n low clears the parser to wait for a string start and empties
// the output register.
module ascii_integer_parser
  import aip_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // [7:0] char_code, [12:8] base_request
  input  logic                   in_tuser,  // [0] start_flag
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata  // [63:0] parsed_value, [79:64] end_offset
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  phase_t                   phase_r, phase_nxt;
  logic                     neg_r, neg_nxt;
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic [VALUE_WIDTH-1:0]   acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                     hd_r, hd_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  logic                     in_fire;
  logic [7:0]               ch;
  digit_t                   dig;
  logic                     is_ws;

  phase_t                   ph_e;
  logic                     neg_e;
  logic [BASE_W-1:0]        base_e;
  logic [VALUE_WIDTH-1:0]   acc_e;
  logic [COUNT_WIDTH-1:0]   cnt_e;
  logic                     hd_e;
  logic [COUNT_WIDTH-1:0]   cnt_bump;

  logic                     take;
  logic [BASE_W-1:0]        take_base;
  logic [VALUE_WIDTH-1:0]   prod;
  logic                     emit;
  logic [VALUE_WIDTH-1:0]   emit_val;
  logic [COUNT_WIDTH-1:0]   emit_cnt;
  logic signed [VALUE_WIDTH-1:0] res_val;
  logic [31:0]              cnt_ext;
  logic [RES_CNT_W-1:0]     res_cnt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign ch        = in_tdata[7:0];
  assign dig       = char_digit(ch);
  assign is_ws     = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);

  always_comb begin
    if (in_tuser) begin
      ph_e   = PH_LEAD;
      neg_e  = 1'b0;
      base_e = in_tdata[12:8];
      acc_e  = '0;
      cnt_e  = '0;
      hd_e   = 1'b0;
    end else begin
      ph_e   = phase_r;
      neg_e  = neg_r;
      base_e = base_r;
      acc_e  = acc_r;
      cnt_e  = cnt_r;
      hd_e   = hd_r;
    end
  end

  assign cnt_bump = (cnt_e < CNT_MAX) ? cnt_e + 1'b1 : cnt_e;
  assign prod     = acc_e * VALUE_WIDTH'(take_base);

  always_comb begin
    phase_nxt = ph_e;
    neg_nxt   = neg_e;
    base_nxt  = base_e;
    acc_nxt   = acc_e;
    cnt_nxt   = cnt_e;
    hd_nxt    = hd_e;
    take      = 1'b0;
    take_base = base_e;
    emit      = 1'b0;
    emit_val  = '0;
    emit_cnt  = '0;

    case (ph_e)
      PH_LEAD, PH_SIGNED: begin
        if (ph_e == PH_LEAD && is_ws) begin
          cnt_nxt = cnt_bump;
        end else if (ph_e == PH_LEAD && (ch == CH_MINUS || ch == CH_PLUS)) begin
          neg_nxt   = (ch == CH_MINUS);
          cnt_nxt   = cnt_bump;
          phase_nxt = PH_SIGNED;
        end else if ((base_e == BASE_AUTO || base_e == BASE_HEX) && ch == CH_ZERO) begin
          cnt_nxt   = cnt_bump;
          acc_nxt   = '0;
          hd_nxt    = 1'b1;
          phase_nxt = PH_ZERO;
        end else begin
          take      = 1'b1;
          take_base = (base_e == BASE_AUTO) ? BASE_DEC : base_e;
        end
      end
      PH_ZERO: begin
        if ((ch | CH_CASE) == CH_LC_X) begin
          cnt_nxt   = cnt_bump;
          base_nxt  = BASE_HEX;
          phase_nxt = PH_PREFIX;
        end else begin
          take      = 1'b1;
          take_base = (base_e == BASE_AUTO) ? BASE_OCT : base_e;
        end
      end
      PH_PREFIX: begin
        if (dig.ok) begin
          take = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_cnt  = (cnt_e != '0) ? cnt_e - 1'b1 : '0;
          phase_nxt = PH_DONE;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    if (take) begin
      base_nxt = take_base;
      if (dig.ok && {1'b0, dig.val} < take_base) begin
        acc_nxt   = prod + VALUE_WIDTH'(dig.val);
        cnt_nxt   = cnt_bump;
        hd_nxt    = 1'b1;
        phase_nxt = PH_DIGITS;
      end else begin
        emit      = 1'b1;
        emit_val  = hd_e ? acc_e : '0;
        emit_cnt  = hd_e ? cnt_e : '0;
        phase_nxt = PH_DONE;
      end
    end
  end

  assign res_val = neg_e ? -emit_val : emit_val;
  assign cnt_ext = 32'(emit_cnt);
  assign res_cnt = (cnt_ext > 32'h0000_FFFF) ? '1 : cnt_ext[RES_CNT_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {res_cnt, RES_VAL_W'(res_val)};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      neg_r       <= 1'b0;
      base_r      <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      hd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        hd_r    <= hd_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit |=> phase_r == PH_DONE && out_valid_r)
    else $error("result without return to idle");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_DONE && !in_tuser |-> !emit)
    else $error("result while idle");

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tuser |=> cnt_r >= $past(cnt_r))
    else $error("count went down within a string");

  a_digit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DIGITS || phase_r == PH_ZERO || phase_r == PH_PREFIX |-> hd_r)
    else $error("digit phase without digit");

endmodule

>>> bench/parse_checker.sv
`timescale 1ns / 100ps

module parse_checker
  import aip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code, [12:8] base_request
  input  logic                   in_tuser,   // [0] start_flag
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] parsed_value, [79:64] end_offset
  output int                     fails,
  output int                     pending,
  output int                     results_seen
);

  typedef struct packed {
    logic [RES_VAL_W-1:0] value;
    logic [RES_CNT_W-1:0] offset;
  } parse_result_t;

  parse_result_t       value_q[$];
  phase_t              ph;
  logic                neg;
  logic [BASE_W-1:0]   radix;
  logic [RES_VAL_W-1:0] acc;
  logic [RES_CNT_W-1:0] taken;
  logic                seen_digit;
  int                  err_cnt;
  int                  got_cnt;

  assign fails        = err_cnt;
  assign results_seen = got_cnt;

  function automatic int digit_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
    return -1;
  endfunction

  function automatic void bump_taken();
    if (taken != '1) taken = taken + 1'b1;
  endfunction

  function automatic void close_parse(input logic [RES_VAL_W-1:0] v,
                                      input logic [RES_CNT_W-1:0] n);
    parse_result_t r;
    r.value  = neg ? (64'd0 - v) : v;
    r.offset = n;
    value_q.push_back(r);
    ph = PH_DONE;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int d;
    d = digit_of(c);
    if (d >= 0 && d < int'(radix)) begin
      acc = acc * {59'd0, radix} + 64'(d);
      bump_taken();
      seen_digit = 1'b1;
      ph = PH_DIGITS;
    end else if (!seen_digit) begin
      close_parse('0, '0);
    end else begin
      close_parse(acc, taken);
    end
  endfunction

  function automatic void after_sign(input logic [7:0] c);
    if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
      bump_taken();
      acc = '0;
      seen_digit = 1'b1;
      ph = PH_ZERO;
    end else begin
      if (radix == BASE_AUTO) radix = BASE_DEC;
      take_digit(c);
    end
  endfunction

  function automatic void predict_char(input logic [7:0] c, input logic st,
                                       input logic [BASE_W-1:0] b);
    if (st) begin
      ph = PH_LEAD;
      neg = 1'b0;
      radix = b;
      acc = '0;
      taken = '0;
      seen_digit = 1'b0;
    end
    case (ph)
      PH_LEAD: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          bump_taken();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          neg = (c == CH_MINUS);
          bump_taken();
          ph = PH_SIGNED;
        end else begin
          after_sign(c);
        end
      end
      PH_SIGNED: after_sign(c);
      PH_ZERO: begin
        if ((c | CH_CASE) == CH_LC_X) begin
          bump_taken();
          radix = BASE_HEX;
          ph = PH_PREFIX;
        end else begin
          if (radix == BASE_AUTO) radix = BASE_OCT;
          take_digit(c);
        end
      end
      PH_PREFIX: begin
        if (digit_of(c) >= 0) take_digit(c);
        else close_parse('0, (taken != '0) ? taken - 1'b1 : taken);
      end
      PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      value_q.delete();
      ph = PH_DONE;
      neg = 1'b0;
      radix = '0;
      acc = '0;
      taken = '0;
      seen_digit = 1'b0;
      err_cnt = 0;
      got_cnt = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_cnt++;
        if (value_q.size() == 0) begin
          $error("result transfer with nothing expected: value %0d, offset %0d",
                 $signed(out_tdata[63:0]), out_tdata[79:64]);
          err_cnt++;
        end else begin
          want = value_q.pop_front();
          if (out_tdata[63:0] !== want.value) begin
            $error("parsed_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_tdata[63:0]));
            err_cnt++;
          end
          if (out_tdata[79:64] !== want.offset) begin
            $error("end_offset: expected %0d, got %0d", want.offset, out_tdata[79:64]);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_char(in_tdata[7:0], in_tuser, in_tdata[12:8]);
    end
    pending <= value_q.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import aip_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_OFF     = 400;
  localparam int RANDOM_CHARS = 900;
  localparam int DRAIN_WAIT   = 20;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int         fails;
  int         pending;
  int         results_seen;
  int         chars_sent;
  int         strings_sent;
  int         quiet;
  bit         tx_idle_on;
  bit         rx_idle_on;
  bit         squeeze_req;
  bit         squeeze_done;
  logic [7:0] txt[$];

  ascii_integer_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  parse_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fails        (fails),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: per-result stall, one long hold-off on request
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        stall = HOLD_OFF;
        squeeze_done = 1'b1;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 7) == 0) rx_idle_on = !rx_idle_on;
    end
  end

  task automatic put_char(input logic [7:0] c, input logic st, input logic [BASE_W-1:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, b, c};
    in_tuser  <= st;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  task automatic send_text(input logic [BASE_W-1:0] b);
    foreach (txt[i]) put_char(txt[i], i == 0, b);
    strings_sent++;
    txt.delete();
  endtask

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  task automatic send_random_string();
    logic [BASE_W-1:0] b;
    int                eff;
    int                n;
    int                tail;
    case ($urandom_range(0, 9))
      0, 1, 2: b = BASE_AUTO;
      3:       b = BASE_OCT;
      4, 5:    b = BASE_DEC;
      6, 7:    b = BASE_HEX;
      8:       b = BASE_W'($urandom_range(1, 16));
      default: b = BASE_W'($urandom_range(0, 31));
    endcase
    repeat ($urandom_range(0, 2)) txt.push_back(pick_blank());
    case ($urandom_range(0, 3))
      0:       txt.push_back(CH_MINUS);
      1:       txt.push_back(CH_PLUS);
      default: ;
    endcase
    eff = (b > BASE_HEX) ? 16 : int'(b);
    if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 2) == 0) begin
      txt.push_back(CH_ZERO);
      txt.push_back($urandom_range(0, 1) ? CH_LC_X : (CH_LC_X & ~CH_CASE));
      eff = 16;
    end else if (b == BASE_AUTO) begin
      if ($urandom_range(0, 2) == 0) begin
        txt.push_back(CH_ZERO);
        eff = 8;
      end else begin
        eff = 10;
      end
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 26) : $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0) txt.push_back(8'($urandom_range(0, 255)));
      else txt.push_back(digit_char($urandom_range(0, eff - 1)));
    end
    tail = $urandom_range(0, 9);
    if (tail <= 3) txt.push_back(8'h00);
    else if (tail <= 7) txt.push_back(8'($urandom_range(0, 255)));
    else if (tail == 9) repeat ($urandom_range(2, 4)) txt.push_back(8'($urandom_range(0, 255)));
    if (txt.size() == 0) txt.push_back(8'h00);
    send_text(b);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_on = 1'b1;
    txt.push_back(8'h09);
    txt.push_back(8'h0A);
    add_str("-0x7fZ");
    send_text(BASE_AUTO);
    txt.push_back(8'h0B);
    add_str("+017");
    txt.push_back(8'h00);
    send_text(BASE_AUTO);
    add_str("0Xg");
    send_text(BASE_HEX);
    txt.push_back(8'h0C);
    txt.push_back(8'h0D);
    txt.push_back(CH_PLUS);
    txt.push_back(8'hFF);
    send_text(BASE_DEC);
    add_str("01");
    send_text(5'd1);
    add_str("fG");
    send_text(5'd31);
    put_char(CH_ZERO + 8'd5, 1'b0, BASE_DEC);
    add_str("12");
    send_text(BASE_DEC);
    add_str("9");
    txt.push_back(8'h00);
    send_text(BASE_DEC);

    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent > 300) squeeze_req = 1'b1;
      if ($urandom_range(0, 7) == 0) tx_idle_on = !tx_idle_on;
      send_random_string();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d characters in %0d strings and %0d compared results,",
             chars_sent, strings_sent, results_seen);
    $display("radix 0 to 31, prefixes, signs, wrap-around and a long output stall.");
    if (fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/aip_pkg.sv
rtl/ascii_integer_parser.sv
bench/parse_checker.sv
bench/tb.sv
